// ----- rtl/lkt_pkg.sv -----
// Package for the lease lock table: sizes, command and status codes,
// and the request and response beat types.
// No dependencies; every other file refers to it by scoped names.
package lkt_pkg;

  localparam int ENTRIES     = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int OWNER_WIDTH = 32;

  localparam int CMD_W    = 3;
  localparam int KEY_IN_W = 32;
  localparam int OWN_IN_W = 32;
  localparam int TTL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int TIME_W   = 48;

  // Only the low bits of key and owner take part in matching.
  localparam int KEY_USE_W = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
  localparam int OWN_USE_W = (OWNER_WIDTH < OWN_IN_W) ? OWNER_WIDTH : OWN_IN_W;

  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TRY    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RENEW  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UNLOCK = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_ENABLED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ARGS    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HELD        = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_MISMATCH    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd6;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [KEY_IN_W-1:0] key_id;
    logic [OWN_IN_W-1:0] owner_id;
    logic [TTL_W-1:0]    ttl_ms;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OWN_IN_W-1:0] holder_owner;
    logic [TIME_W-1:0]   holder_expire;
  } rsp_t;

endpackage

// ----- rtl/lkt_if.sv -----
// Handshake channels of the lease lock table: request and response.
// Depends on lkt_pkg for field widths.
interface lkt_in_if;
  logic                          valid;
  logic                          ready;
  logic [lkt_pkg::CMD_W-1:0]     command;
  logic [lkt_pkg::KEY_IN_W-1:0]  key_id;
  logic [lkt_pkg::OWN_IN_W-1:0]  owner_id;
  logic [lkt_pkg::TTL_W-1:0]     ttl_ms;

  modport source (output valid, command, key_id, owner_id, ttl_ms, input ready);
  modport sink (input valid, command, key_id, owner_id, ttl_ms, output ready);
endinterface

interface lkt_out_if;
  logic                          valid;
  logic                          ready;
  logic [lkt_pkg::STATUS_W-1:0]  status;
  logic [lkt_pkg::OWN_IN_W-1:0]  holder_owner;
  logic [lkt_pkg::TIME_W-1:0]    holder_expire;

  modport source (output valid, status, holder_owner, holder_expire, input ready);
  modport sink (input valid, status, holder_owner, holder_expire, output ready);
endinterface

// ----- rtl/lkt_in_stage.sv -----
// Input register of the lease lock table: holds one request beat until
// the table takes it. Depends on lkt_pkg.
module lkt_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lkt_pkg::req_t in_req,
  input  logic          take,
  output logic          req_vld,
  output lkt_pkg::req_t req
);

  logic          vld_r;
  logic          vld_nxt;
  lkt_pkg::req_t req_r;

  assign in_ready = !vld_r || take;
  assign vld_nxt  = in_ready ? in_valid : vld_r;
  assign req_vld  = vld_r;
  assign req      = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req;
    end
  end

endmodule

// ----- rtl/lkt_table.sv -----
// Lock table: entry flops, clock, associative lookup, free-entry pick and
// the per-command decision, all in one pass. Depends on lkt_pkg.
module lkt_table (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          enable,
  input  logic          req_vld,
  input  lkt_pkg::req_t req,
  input  logic          out_free,
  output logic          take,
  output logic          rsp_vld,
  output lkt_pkg::rsp_t rsp
);

  localparam int E  = lkt_pkg::ENTRIES;
  localparam int TW = lkt_pkg::TIME_W;

  logic [E-1:0]                    valid_r;
  logic [E-1:0]                    valid_nxt;
  logic [TW-1:0]                   clock_r;
  logic [lkt_pkg::KEY_USE_W-1:0]   key_r    [E];
  logic [lkt_pkg::OWN_USE_W-1:0]   owner_r  [E];
  logic [TW-1:0]                   expire_r [E];

  logic [lkt_pkg::KEY_USE_W-1:0]   key;
  logic [lkt_pkg::OWN_USE_W-1:0]   owner;
  logic [E-1:0]                    live;
  logic [E-1:0]                    hit;
  logic [E-1:0]                    free_vec;
  logic [E-1:0]                    free_oh;
  logic [lkt_pkg::OWN_USE_W-1:0]   hit_owner;
  logic [TW-1:0]                   hit_exp;
  logic                            found;
  logic                            owner_eq;
  logic [TW:0]                     sum;
  logic [TW-1:0]                   exp_new;
  logic                            bad;
  logic                            is_tick;
  logic                            has_result;
  logic                            do_clear;
  logic [E-1:0]                    exp_we;
  logic [E-1:0]                    ins_we;
  logic [E-1:0]                    unl_oh;
  logic [lkt_pkg::STATUS_W-1:0]    status;

  always_comb begin
    key   = req.key_id[lkt_pkg::KEY_USE_W-1:0];
    owner = req.owner_id[lkt_pkg::OWN_USE_W-1:0];
    hit_owner = '0;
    hit_exp   = '0;
    for (int i = 0; i < E; i++) begin
      live[i] = valid_r[i] && (clock_r < expire_r[i]);
      hit[i]  = live[i] && (key_r[i] == key);
      // Live keys are unique, so at most one entry hits.
      hit_owner = hit_owner | (hit[i] ? owner_r[i] : '0);
      hit_exp   = hit_exp | (hit[i] ? expire_r[i] : '0);
    end
    found    = |hit;
    owner_eq = (hit_owner == owner);
    free_vec = ~live;
    free_oh  = free_vec & (~free_vec + E'(1));

    sum     = {1'b0, clock_r} + (TW + 1)'(req.ttl_ms);
    exp_new = sum[TW] ? '1 : sum[TW-1:0];

    is_tick    = enable && (req.command == lkt_pkg::CMD_TICK);
    has_result = !is_tick;
    bad = (req.command > lkt_pkg::CMD_QUERY) || (key == '0) ||
          ((req.command != lkt_pkg::CMD_QUERY) && (owner == '0)) ||
          (((req.command == lkt_pkg::CMD_TRY) || (req.command == lkt_pkg::CMD_RENEW)) &&
           (req.ttl_ms == '0));

    do_clear = 1'b0;
    exp_we   = '0;
    ins_we   = '0;
    unl_oh   = '0;
    rsp      = '0;
    status   = lkt_pkg::ST_OK;

    priority if (!enable) begin
      status = lkt_pkg::ST_NOT_ENABLED;
    end else if (is_tick) begin
      status = lkt_pkg::ST_OK;
    end else if (bad) begin
      status = lkt_pkg::ST_BAD_ARGS;
    end else begin
      do_clear = 1'b1;
      if (req.command == lkt_pkg::CMD_TRY) begin
        if (found) begin
          if (owner_eq) begin
            exp_we = hit;
          end else begin
            status = lkt_pkg::ST_HELD;
          end
        end else if (free_vec == '0) begin
          status = lkt_pkg::ST_FULL;
        end else begin
          ins_we = free_oh;
        end
      end else if (!found) begin
        status = lkt_pkg::ST_NOT_FOUND;
      end else if (req.command == lkt_pkg::CMD_QUERY) begin
        rsp.holder_owner  = lkt_pkg::OWN_IN_W'(hit_owner);
        rsp.holder_expire = hit_exp;
      end else if (!owner_eq) begin
        status = lkt_pkg::ST_MISMATCH;
      end else if (req.command == lkt_pkg::CMD_RENEW) begin
        exp_we = hit;
      end else begin
        unl_oh = hit;
      end
    end
    rsp.status = status;

    take    = req_vld && (!has_result || out_free);
    rsp_vld = take && has_result;

    // Expired entries are dropped only where a checked command runs, since
    // the clock may wrap and bring an unswept entry back to life.
    valid_nxt = valid_r;
    if (take && do_clear) begin
      valid_nxt = (live | ins_we) & ~unl_oh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      clock_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (take && is_tick) begin
        clock_r <= clock_r + TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < E; i++) begin
      if (take && ins_we[i]) begin
        key_r[i]   <= key;
        owner_r[i] <= owner;
      end
      if (take && (ins_we[i] || exp_we[i])) begin
        expire_r[i] <= exp_new;
      end
    end
  end

endmodule

// ----- rtl/lkt_out_stage.sv -----
// Output register of the lease lock table: holds one response beat until
// the consumer takes it. Depends on lkt_pkg.
module lkt_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rsp_vld,
  input  lkt_pkg::rsp_t rsp,
  output logic          out_free,
  output logic          out_valid,
  input  logic          out_ready,
  output lkt_pkg::rsp_t out_rsp
);

  logic          vld_r;
  logic          vld_nxt;
  lkt_pkg::rsp_t rsp_r;

  assign out_free  = !vld_r || out_ready;
  assign vld_nxt   = rsp_vld || (vld_r && !out_ready);
  assign out_valid = vld_r;
  assign out_rsp   = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_vld) begin
      rsp_r <= rsp;
    end
  end

endmodule

// ----- rtl/lease_lock_table.sv -----
// Top level of the lease lock table: input register, lock table, output register.
// Depends on lkt_pkg, lkt_in_if, lkt_out_if, lkt_in_stage, lkt_table, lkt_out_stage.

// A table of lkt_pkg::ENTRIES timed locks kept in flops. One request beat can be
// taken every clock cycle while the response side keeps up. A response beat is
// loaded into the output register when the table takes its request from the input
// register, and waits there until the consumer takes it. A response that waits in
// the output register holds a request that needs a response in the input register,
// and that in turn holds off the next request beat; an enabled tick still passes.
// The whole lookup (key match and expiry compare on all entries, lowest free entry
// pick, saturating expiry add) is done in one pass between those registers.
// An enabled tick advances the clock and gives no response beat; every other
// request gives exactly one. Write enable through cfg_we only while idle.
module lease_lock_table (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  lkt_in_if.sink    in_bus,
  lkt_out_if.source out_bus
);

  logic          enable_r;
  lkt_pkg::req_t in_req;
  lkt_pkg::req_t req;
  lkt_pkg::rsp_t rsp;
  lkt_pkg::rsp_t out_rsp;
  logic          req_vld;
  logic          take;
  logic          rsp_vld;
  logic          out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_we) begin
      enable_r <= cfg_wdata;
    end
  end

  assign in_req.command  = in_bus.command;
  assign in_req.key_id   = in_bus.key_id;
  assign in_req.owner_id = in_bus.owner_id;
  assign in_req.ttl_ms   = in_bus.ttl_ms;

  lkt_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .in_req   (in_req),
    .take     (take),
    .req_vld  (req_vld),
    .req      (req)
  );

  lkt_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .enable   (enable_r),
    .req_vld  (req_vld),
    .req      (req),
    .out_free (out_free),
    .take     (take),
    .rsp_vld  (rsp_vld),
    .rsp      (rsp)
  );

  lkt_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_vld   (rsp_vld),
    .rsp       (rsp),
    .out_free  (out_free),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_rsp   (out_rsp)
  );

  assign out_bus.status        = out_rsp.status;
  assign out_bus.holder_owner  = out_rsp.holder_owner;
  assign out_bus.holder_expire = out_rsp.holder_expire;

endmodule

// ----- rtl/lkt_checker.sv -----
// Port-level checks of the lease lock table and their bind to the top level.
// Depends on lkt_pkg and lease_lock_table.
module lkt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lkt_pkg::STATUS_W-1:0]  out_status,
  input logic [lkt_pkg::OWN_IN_W-1:0]  out_owner,
  input logic [lkt_pkg::TIME_W-1:0]    out_expire
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("response beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_owner) &&
    $stable(out_expire))
    else $error("response beat changed while stalled");

  // Holder fields are only filled by a successful query.
  a_holder_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != lkt_pkg::ST_OK) |-> (out_owner == '0) && (out_expire == '0))
    else $error("holder fields set on a failed request");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response beat present after reset");

endmodule

bind lease_lock_table lkt_checker u_lkt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_status (out_bus.status),
  .out_owner  (out_bus.holder_owner),
  .out_expire (out_bus.holder_expire)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for lease_lock_table: a scoreboard class predicts every
// response beat from its own copy of the lease table; tasks drive the request channel.
// Depends on lkt_pkg, lkt_in_if, lkt_out_if and the lease_lock_table RTL.
module testbench;

  localparam logic [lkt_pkg::CMD_W-1:0] CMD_UNDEF_FIRST = 3'd5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int SETTLE_CYCLES = 4;

  class lease_scoreboard;
    bit                           enabled;
    logic [lkt_pkg::TIME_W-1:0]   now_ms;
    bit                           lease_live[lkt_pkg::ENTRIES];
    logic [lkt_pkg::KEY_IN_W-1:0] lease_key[lkt_pkg::ENTRIES];
    logic [lkt_pkg::OWN_IN_W-1:0] lease_owner[lkt_pkg::ENTRIES];
    logic [lkt_pkg::TIME_W-1:0]   lease_end[lkt_pkg::ENTRIES];
    lkt_pkg::rsp_t                awaited_rsp[$];
    int                           errors;
    int                           checked;
    int                           cmd_count[8];
    int                           status_count[8];

    function new();
      enabled = 0;
      now_ms = '0;
      foreach (lease_live[i]) lease_live[i] = 0;
    endfunction

    function logic [lkt_pkg::TIME_W-1:0] lease_end_for(logic [lkt_pkg::TTL_W-1:0] ttl);
      logic [lkt_pkg::TIME_W:0] sum;
      sum = {1'b0, now_ms} + (lkt_pkg::TIME_W + 1)'(ttl);
      return sum[lkt_pkg::TIME_W] ? {lkt_pkg::TIME_W{1'b1}} : sum[lkt_pkg::TIME_W-1:0];
    endfunction

    // Works out the response beat, if any, that an accepted request causes.
    function void note_request(lkt_pkg::req_t r);
      lkt_pkg::rsp_t want;
      logic [lkt_pkg::KEY_IN_W-1:0] key;
      logic [lkt_pkg::OWN_IN_W-1:0] owner;
      int hit;
      int slot;
      want = '0;
      key = '0;
      owner = '0;
      key[lkt_pkg::KEY_USE_W-1:0] = r.key_id[lkt_pkg::KEY_USE_W-1:0];
      owner[lkt_pkg::OWN_USE_W-1:0] = r.owner_id[lkt_pkg::OWN_USE_W-1:0];
      hit = -1;
      slot = -1;
      cmd_count[r.command]++;
      if (!enabled) begin
        want.status = lkt_pkg::ST_NOT_ENABLED;
      end else if (r.command == lkt_pkg::CMD_TICK) begin
        now_ms = now_ms + lkt_pkg::TIME_W'(1);
        return;
      end else if (r.command > lkt_pkg::CMD_QUERY || key == '0 ||
                   (r.command != lkt_pkg::CMD_QUERY && owner == '0) ||
                   ((r.command == lkt_pkg::CMD_TRY || r.command == lkt_pkg::CMD_RENEW) &&
                    r.ttl_ms == '0)) begin
        want.status = lkt_pkg::ST_BAD_ARGS;
      end else begin
        // Leases whose end time has been reached are dropped before the lookup.
        for (int i = 0; i < lkt_pkg::ENTRIES; i++)
          if (lease_live[i] && now_ms >= lease_end[i]) lease_live[i] = 0;
        for (int i = 0; i < lkt_pkg::ENTRIES; i++)
          if (hit < 0 && lease_live[i] && lease_key[i] == key) hit = i;
        case (r.command)
          lkt_pkg::CMD_TRY: begin
            if (hit >= 0) begin
              if (lease_owner[hit] == owner) begin
                lease_end[hit] = lease_end_for(r.ttl_ms);
                want.status = lkt_pkg::ST_OK;
              end else begin
                want.status = lkt_pkg::ST_HELD;
              end
            end else begin
              for (int i = 0; i < lkt_pkg::ENTRIES; i++)
                if (slot < 0 && !lease_live[i]) slot = i;
              if (slot < 0) begin
                want.status = lkt_pkg::ST_FULL;
              end else begin
                lease_live[slot] = 1;
                lease_key[slot] = key;
                lease_owner[slot] = owner;
                lease_end[slot] = lease_end_for(r.ttl_ms);
                want.status = lkt_pkg::ST_OK;
              end
            end
          end
          lkt_pkg::CMD_QUERY: begin
            if (hit < 0) begin
              want.status = lkt_pkg::ST_NOT_FOUND;
            end else begin
              want.status = lkt_pkg::ST_OK;
              want.holder_owner = lease_owner[hit];
              want.holder_expire = lease_end[hit];
            end
          end
          default: begin
            if (hit < 0) begin
              want.status = lkt_pkg::ST_NOT_FOUND;
            end else if (lease_owner[hit] != owner) begin
              want.status = lkt_pkg::ST_MISMATCH;
            end else begin
              if (r.command == lkt_pkg::CMD_RENEW) lease_end[hit] = lease_end_for(r.ttl_ms);
              else lease_live[hit] = 0;
              want.status = lkt_pkg::ST_OK;
            end
          end
        endcase
      end
      awaited_rsp.push_back(want);
    endfunction

    task report(string msg);
      if (errors < 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_response(lkt_pkg::rsp_t got);
      lkt_pkg::rsp_t want;
      if (awaited_rsp.size() == 0) begin
        report($sformatf("response beat with nothing expected (status %0d)", got.status));
      end else begin
        want = awaited_rsp.pop_front();
        checked++;
        if (!$isunknown(got.status)) status_count[got.status]++;
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.holder_owner !== want.holder_owner)
          report($sformatf("holder_owner %h, expected %h", got.holder_owner,
                           want.holder_owner));
        if (got.holder_expire !== want.holder_expire)
          report($sformatf("holder_expire %h, expected %h", got.holder_expire,
                           want.holder_expire));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  bit   in_idle_on;
  bit   out_idle_on;
  int   idle_cycles;
  int   sent;

  logic [lkt_pkg::KEY_IN_W-1:0] key_pool[24];
  logic [lkt_pkg::OWN_IN_W-1:0] owner_pool[3];

  lease_scoreboard sb;

  lkt_in_if  in_bus();
  lkt_out_if out_bus();

  lease_lock_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_bus   (in_bus),
    .out_bus  (out_bus)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_bus.ready = !(out_idle_on && $urandom_range(99) < 28);
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      sb.check_response('{out_bus.status, out_bus.holder_owner, out_bus.holder_expire});
    end
  end

  // Any beat on either channel counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic lkt_pkg::req_t make_req(logic [lkt_pkg::CMD_W-1:0] cmd,
                                             logic [lkt_pkg::KEY_IN_W-1:0] key,
                                             logic [lkt_pkg::OWN_IN_W-1:0] owner,
                                             logic [lkt_pkg::TTL_W-1:0] ttl);
    lkt_pkg::req_t r;
    r.command = cmd;
    r.key_id = key;
    r.owner_id = owner;
    r.ttl_ms = ttl;
    return r;
  endfunction

  function automatic lkt_pkg::req_t random_request();
    lkt_pkg::req_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) r.command = lkt_pkg::CMD_TICK;
    else if (pick < 55) r.command = lkt_pkg::CMD_TRY;
    else if (pick < 67) r.command = lkt_pkg::CMD_RENEW;
    else if (pick < 80) r.command = lkt_pkg::CMD_UNLOCK;
    else if (pick < 96) r.command = lkt_pkg::CMD_QUERY;
    else r.command = CMD_UNDEF_FIRST + lkt_pkg::CMD_W'($urandom_range(2));
    pick = $urandom_range(99);
    if (pick < 92) r.key_id = key_pool[$urandom_range(23)];
    else if (pick < 96) r.key_id = $urandom;
    else r.key_id = '0;
    pick = $urandom_range(99);
    if (pick < 93) r.owner_id = owner_pool[$urandom_range(2)];
    else if (pick < 97) r.owner_id = $urandom;
    else r.owner_id = '0;
    pick = $urandom_range(99);
    if (pick < 85) r.ttl_ms = $urandom_range(40, 1);
    else if (pick < 96) r.ttl_ms = $urandom_range(400, 41);
    else if (pick < 97) r.ttl_ms = $urandom;
    else r.ttl_ms = '0;
    return r;
  endfunction

  // Holds the beat on the bus until the block takes it; valid stays high afterwards
  // so that back-to-back beats need no toggle.
  task automatic send_request(input lkt_pkg::req_t r);
    @(negedge clk);
    while (in_idle_on && $urandom_range(99) < 28) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.command = r.command;
    in_bus.key_id = r.key_id;
    in_bus.owner_id = r.owner_id;
    in_bus.ttl_ms = r.ttl_ms;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_request(r);
    sent++;
  endtask

  // An enabled tick leaves nothing to wait for, so the task also lets the block settle.
  task automatic wait_quiet();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (sb.awaited_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input bit value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.enabled = value;
  endtask

  // Many try_locks on distinct keys in a row, so the table fills up.
  task automatic fill_burst();
    int first;
    first = $urandom_range(23);
    for (int n = 0; n < 18; n++) begin
      send_request(make_req(lkt_pkg::CMD_TRY, key_pool[(first + n) % 24],
                            owner_pool[$urandom_range(2)], $urandom_range(200, 20)));
    end
  endtask

  initial begin
    lkt_pkg::req_t directed[$];
    bit paused;
    bit disabled_again;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    sent = 0;
    paused = 0;
    disabled_again = 0;
    in_bus.valid = 1'b0;
    in_bus.command = lkt_pkg::CMD_TICK;
    in_bus.key_id = '0;
    in_bus.owner_id = '0;
    in_bus.ttl_ms = '0;
    for (int i = 0; i < 24; i++) begin
      key_pool[i] = (i < 6) ? lkt_pkg::KEY_IN_W'(i + 1) : $urandom;
      if (key_pool[i] == '0) key_pool[i] = lkt_pkg::KEY_IN_W'(i + 100);
    end
    owner_pool[0] = lkt_pkg::OWN_IN_W'(1);
    owner_pool[1] = {lkt_pkg::OWN_IN_W{1'b1}};
    owner_pool[2] = $urandom | 32'h0000_0100;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Out of reset the block is disabled and refuses everything, ticks included.
    send_request(make_req(lkt_pkg::CMD_TICK, '0, '0, '0));
    send_request(make_req(lkt_pkg::CMD_TRY, 32'h5, 32'h1, 32'h9));
    send_request(make_req(lkt_pkg::CMD_RENEW, 32'h5, 32'h1, 32'h9));
    send_request(make_req(lkt_pkg::CMD_UNLOCK, 32'h5, 32'h1, '0));
    send_request(make_req(lkt_pkg::CMD_QUERY, 32'h5, '0, '0));
    send_request(make_req(CMD_UNDEF_FIRST + 3'd1, 32'h5, 32'h1, 32'h1));
    wait_quiet();
    write_enable(1'b1);

    directed.push_back(make_req(lkt_pkg::CMD_TRY, '0, 32'h1, 32'h5));
    directed.push_back(make_req(lkt_pkg::CMD_TRY, 32'h7, '0, 32'h5));
    directed.push_back(make_req(lkt_pkg::CMD_TRY, 32'h7, 32'h1, '0));
    directed.push_back(make_req(lkt_pkg::CMD_RENEW, 32'h7, 32'h1, '0));
    directed.push_back(make_req(lkt_pkg::CMD_UNLOCK, 32'h7, '0, 32'h5));
    directed.push_back(make_req(lkt_pkg::CMD_QUERY, '0, 32'h1, 32'h5));
    directed.push_back(make_req(CMD_UNDEF_FIRST + 3'd2, 32'h7, 32'h1, 32'h5));
    directed.push_back(make_req(lkt_pkg::CMD_QUERY, 32'hFFFF_FFFF, '0, '0));
    directed.push_back(make_req(lkt_pkg::CMD_TRY, 32'hFFFF_FFFF, 32'h1, 32'h3));
    directed.push_back(make_req(lkt_pkg::CMD_TRY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h3));
    directed.push_back(make_req(lkt_pkg::CMD_TRY, 32'hFFFF_FFFF, 32'h1, 32'h5));
    directed.push_back(make_req(lkt_pkg::CMD_RENEW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h9));
    directed.push_back(make_req(lkt_pkg::CMD_RENEW, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF));
    directed.push_back(make_req(lkt_pkg::CMD_QUERY, 32'hFFFF_FFFF, 32'h1234_5678, 32'h1));
    directed.push_back(make_req(lkt_pkg::CMD_UNLOCK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0));
    directed.push_back(make_req(lkt_pkg::CMD_UNLOCK, 32'hFFFF_FFFF, 32'h1, '0));
    directed.push_back(make_req(lkt_pkg::CMD_UNLOCK, 32'hFFFF_FFFF, 32'h1, '0));
    directed.push_back(make_req(lkt_pkg::CMD_RENEW, 32'hFFFF_FFFF, 32'h1, 32'h4));
    // A one-tick lease is gone as soon as the clock reaches its end time.
    directed.push_back(make_req(lkt_pkg::CMD_TRY, 32'h8000_0000, 32'h1, 32'h1));
    directed.push_back(make_req(lkt_pkg::CMD_TICK, 32'h8000_0000, 32'h1, 32'h1));
    directed.push_back(make_req(lkt_pkg::CMD_QUERY, 32'h8000_0000, '0, '0));
    directed.push_back(make_req(lkt_pkg::CMD_TRY, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF));
    directed.push_back(make_req(lkt_pkg::CMD_UNLOCK, 32'h1, 32'h8000_0000, 32'hFFFF_FFFF));
    foreach (directed[i]) send_request(directed[i]);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      in_idle_on = !(sent >= 200 && sent < 400);
      out_idle_on = in_idle_on;
      if (!paused && sent >= 500) begin
        paused = 1;
        wait_quiet();
      end
      if (!disabled_again && sent >= 650) begin
        disabled_again = 1;
        wait_quiet();
        write_enable(1'b0);
        repeat (20) send_request(random_request());
        wait_quiet();
        write_enable(1'b1);
      end
      if ($urandom_range(99) < 4) fill_burst();
      else send_request(random_request());
    end

    wait_quiet();
    repeat (10) @(posedge clk);
    while (sb.awaited_rsp.size() != 0) begin
      sb.report($sformatf("expected response never arrived (status %0d)",
                          sb.awaited_rsp[0].status));
      void'(sb.awaited_rsp.pop_front());
    end
    $display("Covered %0d tick, %0d try_lock, %0d renew, %0d unlock, %0d query requests",
             sb.cmd_count[lkt_pkg::CMD_TICK], sb.cmd_count[lkt_pkg::CMD_TRY],
             sb.cmd_count[lkt_pkg::CMD_RENEW], sb.cmd_count[lkt_pkg::CMD_UNLOCK],
             sb.cmd_count[lkt_pkg::CMD_QUERY]);
    $display("%0d responses checked: ok %0d, refused %0d, bad %0d, held %0d, absent %0d, %s",
             sb.checked, sb.status_count[lkt_pkg::ST_OK],
             sb.status_count[lkt_pkg::ST_NOT_ENABLED],
             sb.status_count[lkt_pkg::ST_BAD_ARGS], sb.status_count[lkt_pkg::ST_HELD],
             sb.status_count[lkt_pkg::ST_NOT_FOUND],
             $sformatf("wrong owner %0d, full %0d", sb.status_count[lkt_pkg::ST_MISMATCH],
                       sb.status_count[lkt_pkg::ST_FULL]));
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- lease_lock_table.f -----
rtl/lkt_pkg.sv
rtl/lkt_if.sv
rtl/lkt_in_stage.sv
rtl/lkt_table.sv
rtl/lkt_out_stage.sv
rtl/lease_lock_table.sv
rtl/lkt_checker.sv
tb/testbench.sv
